// ----- rtl/core/gcol_pkg.sv -----
// Package with the sizes and command codes of the greedy graph colouring block.
`timescale 1ns / 1ps
package gcol_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int VTX_W        = 8;
    localparam int COLOR_W      = 8;
    localparam int NUM_COLORS   = 1 << COLOR_W;
    localparam int COUNT_W      = COLOR_W + 1;

    // The vertex field is eight bits wide, so no more than 256 entries can ever be addressed.
    localparam int VTX_DEPTH = (MAX_VERTICES < (1 << VTX_W)) ? MAX_VERTICES : (1 << VTX_W);
    localparam int VIDX_W    = (VTX_DEPTH > 1) ? $clog2(VTX_DEPTH) : 1;

    localparam logic CMD_NEIGHBOR = 1'b0;
    localparam logic CMD_START    = 1'b1;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

endpackage

// ----- rtl/core/greedy_graph_coloring.sv -----
// Top level of the first-fit greedy graph colouring block.
//
// Channel  Dir  Word                                        Ends
// s_       in   neighbour item or start command             one per neighbour, tlast on last
// m_       out  coloured vertex, colour, colour count       one per vertex
//
// One input word is taken every cycle while the stage is not held; a result is offered once
// the last word of a vertex has left the processing stage. The rate is set by the single read
// port of the vertex colour memory, read once per word, and by the used-colour mark update.
// Reset is synchronous and active low; it clears the colour marks, the used marks and the
// highest colour. The vertex colour memory is not cleared: only coloured entries are used.
// A stalled result holds the processing stage, which in turn drops s_tready.
`timescale 1ns / 1ps
module greedy_graph_coloring
    import gcol_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // vertex[7:0], neighbor[15:8]
    input  logic [S_TUSER_W-1:0] s_tuser,   // cmd[0], has_neighbor[1]
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // colored_vertex[7:0], assigned_color[15:8],
                                            // colors_in_use[24:16], zero[31:25]
);

    // Input word fields.
    logic             in_cmd;
    logic [VTX_W-1:0] in_vertex;
    logic [VTX_W-1:0] in_neighbor;
    logic             in_has_neighbor;
    logic             in_nbr_ok;
    logic             s_accept;

    // Storage.
    logic [COLOR_W-1:0]    vertex_colors [VTX_DEPTH];
    logic [VTX_DEPTH-1:0]  colored_reg;
    logic [VTX_DEPTH-1:0]  colored_next;
    logic [NUM_COLORS-1:0] used_reg;
    logic [NUM_COLORS-1:0] used_next;
    logic [COLOR_W-1:0]    highest_reg;
    logic [COLOR_W-1:0]    highest_next;

    // Processing stage.
    logic               st_valid_reg;
    logic               st_cmd_reg;
    logic               st_last_reg;
    logic               st_hit_reg;
    logic               st_fwd_reg;
    logic [COLOR_W-1:0] st_fwd_color_reg;
    logic [COLOR_W-1:0] st_rd_color_reg;
    logic [VTX_W-1:0]   st_vertex_reg;
    logic               st_vtx_ok_reg;
    logic               st_result;
    logic               st_advance;
    logic [COLOR_W-1:0] st_nbr_color;
    logic [NUM_COLORS-1:0] st_used;
    logic [COLOR_W-1:0] st_color;
    logic               st_writes;

    // Forwarding decision for the word being accepted.
    logic               fwd_next;
    logic               hit_next;

    // Output register.
    logic               m_valid_reg;
    logic [VTX_W-1:0]   m_vertex_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic [COUNT_W-1:0] m_count_reg;

    assign in_cmd          = s_tuser[0];
    assign in_has_neighbor = s_tuser[1];
    assign in_vertex       = s_tdata[VTX_W-1:0];
    assign in_neighbor     = s_tdata[2*VTX_W-1:VTX_W];
    assign in_nbr_ok       = in_has_neighbor && (32'(in_neighbor) < 32'(MAX_VERTICES));

    assign st_result  = st_valid_reg && (st_cmd_reg == CMD_NEIGHBOR) && st_last_reg;
    assign st_advance = st_valid_reg && (!st_result || !m_valid_reg || m_tready);
    assign s_tready   = !st_valid_reg || st_advance;
    assign s_accept   = s_tvalid && s_tready;

    // The neighbour's colour comes from the memory unless the word just ahead coloured it.
    assign st_nbr_color = st_fwd_reg ? st_fwd_color_reg : st_rd_color_reg;

    always_comb begin
        st_used = used_reg;
        if (st_hit_reg) begin
            st_used[st_nbr_color] = 1'b1;
        end
    end

    // First free colour; saturates at the top colour when every colour is taken.
    always_comb begin
        st_color = COLOR_W'(NUM_COLORS - 1);
        for (int i = NUM_COLORS - 1; i >= 0; i--) begin
            if (!st_used[i]) begin
                st_color = COLOR_W'(i);
            end
        end
    end

    assign st_writes = st_result && st_vtx_ok_reg;

    always_comb begin
        colored_next = colored_reg;
        used_next    = used_reg;
        highest_next = highest_reg;
        if (st_advance) begin
            if (st_cmd_reg == CMD_START) begin
                colored_next = '0;
                used_next    = '0;
                highest_next = '0;
            end else if (st_last_reg) begin
                used_next = '0;
                if (st_vtx_ok_reg) begin
                    colored_next[st_vertex_reg[VIDX_W-1:0]] = 1'b1;
                end
                if (st_color > highest_reg) begin
                    highest_next = st_color;
                end
            end else begin
                used_next = st_used;
            end
        end
    end

    // The word ahead leaves the stage at the same edge as this one is accepted, so its
    // effect on the colour marks and the colour memory is forwarded here.
    always_comb begin
        fwd_next = 1'b0;
        hit_next = 1'b0;
        if (in_nbr_ok) begin
            if (st_valid_reg && (st_cmd_reg == CMD_START)) begin
                hit_next = 1'b0;
            end else if (st_writes && (st_vertex_reg == in_neighbor)) begin
                fwd_next = 1'b1;
                hit_next = 1'b1;
            end else begin
                hit_next = colored_reg[in_neighbor[VIDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_advance && st_writes) begin
            vertex_colors[st_vertex_reg[VIDX_W-1:0]] <= st_color;
        end
        if (s_accept) begin
            st_rd_color_reg <= vertex_colors[in_neighbor[VIDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            colored_reg  <= '0;
            used_reg     <= '0;
            highest_reg  <= '0;
        end else begin
            colored_reg <= colored_next;
            used_reg    <= used_next;
            highest_reg <= highest_next;
            if (s_accept) begin
                st_valid_reg <= 1'b1;
            end else if (st_advance) begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st_cmd_reg       <= in_cmd;
            st_last_reg      <= s_tlast;
            st_hit_reg       <= hit_next;
            st_fwd_reg       <= fwd_next;
            st_fwd_color_reg <= st_color;
            st_vertex_reg    <= in_vertex;
            st_vtx_ok_reg    <= 32'(in_vertex) < 32'(MAX_VERTICES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_advance && st_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_advance && st_result) begin
            m_vertex_reg <= st_vertex_reg;
            m_color_reg  <= st_color;
            m_count_reg  <= COUNT_W'(highest_next) + COUNT_W'(1);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VTX_W - COLOR_W - COUNT_W){1'b0}},
                       m_count_reg, m_color_reg, m_vertex_reg};

endmodule

// ----- dv/tb_greedy_graph_coloring.sv -----
// Self-checking testbench for the greedy first-fit graph colouring block.
`timescale 1ns / 1ps
module tb_greedy_graph_coloring;
    import gcol_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_WORDS = 380;
    localparam int CLIQUE_SIZE  = 20;

    typedef struct packed {
        logic               cmd;
        logic [VTX_W-1:0]   vertex;
        logic [VTX_W-1:0]   neighbor;
        logic               has_neighbor;
        logic               last;
    } colour_word_t;

    typedef struct packed {
        logic [VTX_W-1:0]   vertex;
        logic [COLOR_W-1:0] colour;
        logic [COUNT_W-1:0] in_use;
    } colouring_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_e;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predicted state of the colouring in progress.
    logic [COLOR_W-1:0] colour_of [VTX_DEPTH];
    bit                 is_coloured [VTX_DEPTH];
    bit                 colour_taken [NUM_COLORS];
    logic [COLOR_W-1:0] top_colour = '0;

    colouring_t expected_colourings[$];
    int         fail_count  = 0;
    int         words_sent  = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;

    int       hold_requests = 0;
    int       holds_served  = 0;
    int       hold_left     = 0;
    int       rx_phase      = 0;
    int       rx_tick       = 0;
    rx_mode_e rx_mode       = RX_ALWAYS;

    greedy_graph_coloring i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic bit predict_colouring(input colour_word_t w, output colouring_t r);
        int i;
        int pick;
        r    = '0;
        pick = NUM_COLORS - 1;
        if (w.cmd == CMD_START) begin
            for (i = 0; i < VTX_DEPTH; i++) is_coloured[i] = 1'b0;
            for (i = 0; i < NUM_COLORS; i++) colour_taken[i] = 1'b0;
            top_colour = '0;
            return 1'b0;
        end
        if (w.has_neighbor && int'(w.neighbor) < MAX_VERTICES && is_coloured[w.neighbor])
            colour_taken[colour_of[w.neighbor]] = 1'b1;
        if (!w.last)
            return 1'b0;
        // Lowest free colour; with every colour taken it stays at the top one.
        for (i = NUM_COLORS - 1; i >= 0; i--) begin
            if (!colour_taken[i]) pick = i;
        end
        if (int'(w.vertex) < MAX_VERTICES) begin
            colour_of[w.vertex]   = COLOR_W'(pick);
            is_coloured[w.vertex] = 1'b1;
        end
        if (COLOR_W'(pick) > top_colour) top_colour = COLOR_W'(pick);
        for (i = 0; i < NUM_COLORS; i++) colour_taken[i] = 1'b0;
        r.vertex = w.vertex;
        r.colour = COLOR_W'(pick);
        r.in_use = {1'b0, top_colour} + COUNT_W'(1);
        return 1'b1;
    endfunction

    function automatic colour_word_t word(input logic cmd, input int v, input int n,
                                          input logic has, input logic last);
        colour_word_t w;
        w.cmd          = cmd;
        w.vertex       = VTX_W'(v);
        w.neighbor     = VTX_W'(n);
        w.has_neighbor = has;
        w.last         = last;
        return w;
    endfunction

    function automatic colour_word_t random_word();
        return word(1'($urandom), $urandom_range(0, 255), $urandom_range(0, 255),
                    1'($urandom), 1'($urandom));
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
    endtask

    // Offers one word, with the sender idling between most bursts, and records the prediction
    // once the word has been taken.
    task automatic send_word(input colour_word_t w);
        colouring_t r;
        int         gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.neighbor, w.vertex};
        s_tuser  <= {w.has_neighbor, w.cmd};
        s_tlast  <= w.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        if (predict_colouring(w, r)) expected_colourings.push_back(r);
    endtask

    // One vertex as a run of neighbour words, mostly drawn from the given range.
    task automatic send_vertex(input int v, input int base, input int span, input int degree);
        int k;
        int n;
        if (degree == 0) begin
            send_word(word(CMD_NEIGHBOR, v, $urandom_range(0, 255), 1'b0, 1'b1));
        end else begin
            for (k = 0; k < degree; k++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                : base + $urandom_range(0, span - 1);
                // Only the last word's vertex field matters, so the others carry junk.
                send_word(word(CMD_NEIGHBOR, (k == degree - 1) ? v : $urandom_range(0, 255),
                               n, 1'b1, k == degree - 1));
            end
        end
    endtask

    task automatic test_directed_cases();
        send_word(word(CMD_START, 0, 0, 1'b0, 1'b0));
        // A degree-zero vertex and the field extremes.
        send_word(word(CMD_NEIGHBOR, 0, 255, 1'b0, 1'b1));
        send_word(word(CMD_NEIGHBOR, 255, 0, 1'b1, 1'b1));
        send_word(word(CMD_NEIGHBOR, 8'h5a, 255, 1'b1, 1'b0));
        send_word(word(CMD_NEIGHBOR, 1, 0, 1'b1, 1'b1));
        // An uncoloured neighbour, an ignored word and a vertex naming itself.
        send_word(word(CMD_NEIGHBOR, 0, 200, 1'b1, 1'b0));
        send_word(word(CMD_NEIGHBOR, 0, 0, 1'b0, 1'b0));
        send_word(word(CMD_NEIGHBOR, 2, 2, 1'b1, 1'b1));
        // The same vertex again, now seeing its own colour, so it is recoloured.
        send_word(word(CMD_NEIGHBOR, 2, 2, 1'b1, 1'b0));
        send_word(word(CMD_NEIGHBOR, 2, 255, 1'b1, 1'b1));
        // A start arriving in the middle of a run drops the marks gathered so far.
        send_word(word(CMD_NEIGHBOR, 3, 1, 1'b1, 1'b0));
        send_word(word(CMD_START, 255, 255, 1'b1, 1'b1));
        send_word(word(CMD_NEIGHBOR, 3, 1, 1'b1, 1'b1));
        send_word(word(CMD_NEIGHBOR, 0, 3, 1'b1, 1'b0));
        send_word(word(CMD_NEIGHBOR, 0, 3, 1'b1, 1'b1));
    endtask

    // Builds a clique so that each new vertex takes the next colour, then colours a vertex
    // whose neighbours cover every colour of the clique.
    task automatic test_clique_colours();
        int v;
        send_word(word(CMD_START, 0, 0, 1'b0, 1'b0));
        send_vertex(0, 0, 1, 0);
        for (v = 1; v < CLIQUE_SIZE; v++) begin
            for (int n = 0; n < v; n++)
                send_word(word(CMD_NEIGHBOR, v, n, 1'b1, n == v - 1));
        end
        for (v = 0; v < CLIQUE_SIZE; v++)
            send_word(word(CMD_NEIGHBOR, 128, v, 1'b1, v == CLIQUE_SIZE - 1));
    endtask

    task automatic test_result_backpressure();
        int k;
        send_word(word(CMD_START, 0, 0, 1'b0, 1'b0));
        hold_requests <= hold_requests + 1;
        for (k = 0; k < 40; k++)
            send_vertex(16 + $urandom_range(0, 15), 16, 16, $urandom_range(0, 1));
    endtask

    task automatic test_random_graphs();
        int           first;
        int           base;
        int           span;
        int           pick;
        colour_word_t w;
        first = words_sent;
        span  = $urandom_range(8, 32);
        base  = $urandom_range(0, 256 - span);
        send_word(word(CMD_START, $urandom_range(0, 255), $urandom_range(0, 255),
                       1'($urandom), 1'($urandom)));
        while (words_sent - first < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                w     = random_word();
                w.cmd = CMD_START;
                send_word(w);
                span = $urandom_range(2, 40);
                base = $urandom_range(0, 256 - span);
            end else if (pick < 12) begin
                w     = random_word();
                w.cmd = CMD_NEIGHBOR;
                send_word(w);
            end else if (pick < 16) begin
                send_vertex($urandom_range(0, 255), 0, 256, $urandom_range(0, 4));
            end else begin
                send_vertex(base + $urandom_range(0, span - 1), base, span,
                            ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12)
                                                        : $urandom_range(0, 4));
            end
        end
    endtask

    // Receiver: changes its stall pattern whenever its phase counter runs out, and holds off
    // completely when a long hold is requested.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            if (rx_phase == 0) begin
                rx_mode  <= rx_mode_e'($urandom_range(0, 3));
                rx_phase <= $urandom_range(16, 96);
            end else begin
                rx_phase <= rx_phase - 1;
            end
            case (rx_mode)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_HALF:     m_tready <= 1'($urandom);
                RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        colouring_t exp_col;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_colourings.size() == 0) begin
                note_failure($sformatf("unexpected result word %h", m_tdata));
            end else begin
                exp_col = expected_colourings.pop_front();
                if (m_tdata[7:0] !== exp_col.vertex || m_tdata[15:8] !== exp_col.colour
                        || m_tdata[24:16] !== exp_col.in_use || m_tdata[31:25] !== '0)
                    note_failure($sformatf(
                        "vertex %0d colour %0d in use %0d, expected %0d %0d %0d (word %h)",
                        m_tdata[7:0], m_tdata[15:8], m_tdata[24:16],
                        exp_col.vertex, exp_col.colour, exp_col.in_use, m_tdata));
            end
        end
    end

    // Watchdog: ends the run when no word has moved on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_result_backpressure();
        test_clique_colours();
        test_random_graphs();
        s_tvalid <= 1'b0;
        while (expected_colourings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
